[hdl/depth_fog_tint_blend_top_macros.svh]
// Assertion macros shared by the fog blend RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef DEPTH_FOG_TINT_BLEND_TOP_MACROS_SVH
`define DEPTH_FOG_TINT_BLEND_TOP_MACROS_SVH

`ifndef ASSERT_OFF

// plain invariant, checked at every edge out of reset
`define DFTB_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("dftb check failed");

// same-cycle implication
`define DFTB_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("dftb check failed");

// next-cycle implication
`define DFTB_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("dftb check failed");

`else

`define DFTB_ASSERT(lbl, clk, rst_n, prop)
`define DFTB_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define DFTB_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

[hdl/dftb_pkg.sv]
// Shared types and constants for the depth fog / tint blend block.
// No dependencies; used by every module under hdl except dftb_div.
package dftb_pkg;

	localparam int MAX_DIM_DEF = 4096;

	localparam int START_W = 11;
	localparam int COLOR_W = 24;
	localparam int TINT_W  = 27;
	localparam int DIM_W   = 13;
	localparam int IDX_W   = 3;
	localparam int DATA_W  = 27;
	localparam int FAC_W   = 9;
	localparam int RGB_W   = 24;

	localparam logic [FAC_W-1:0] FAC_ONE = 9'd256;
	localparam logic [7:0]       ALPHA   = 8'hFF;

	localparam logic [START_W-1:0] FOG_NEAR_RST  = 11'd384;
	localparam logic [START_W-1:0] FOG_END_RST   = 11'd1024;
	localparam logic [COLOR_W-1:0] FOG_COLOR_RST = 24'd789012;
	localparam logic [TINT_W-1:0]  TINT_RST      = 27'd134086643;
	localparam logic [DIM_W-1:0]   WIDTH_RST     = 13'd320;
	localparam logic [DIM_W-1:0]   HEIGHT_RST    = 13'd200;

	// power of two
	localparam int FIFO_DEPTH = 4;

	typedef enum logic [IDX_W-1:0] {
		REG_FOG_NEAR  = 3'd0,
		REG_FOG_END   = 3'd1,
		REG_FOG_COLOR = 3'd2,
		REG_TINT      = 3'd3,
		REG_WIDTH     = 3'd4,
		REG_HEIGHT    = 3'd5
	} reg_idx_t;

	// one queued pixel with the fog factor of its row
	typedef struct packed {
		logic [RGB_W-1:0] rgb;
		logic [FAC_W-1:0] fac;
	} fe_t;

endpackage

[hdl/dftb_div.sv]
// Bit-serial restoring divider, one quotient bit per cycle.
// Used by dftb_front for the row depth and fog factor; no package use.
module dftb_div #(
	parameter int NW = 22,
	parameter int DW = 13
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic [NW-1:0] quo
);

	localparam int CW = $clog2(NW + 1);

	logic [DW-1:0] rem_q;
	logic [DW-1:0] den_q;
	logic [NW-1:0] quo_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;

	logic [DW:0]   trial;
	logic          ge;
	logic [DW:0]   diff;

	always_comb begin
		trial = {rem_q, quo_q[NW-1]};
		ge    = trial >= {1'b0, den_q};
		diff  = trial - {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= den;
			quo_q <= num;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
			quo_q <= {quo_q[NW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

[hdl/dftb_front.sv]
// Front end: raster counters, per-row depth and fog factor, queue push.
// Uses dftb_pkg, dftb_div and the assertion macros header.
`include "depth_fog_tint_blend_top_macros.svh"

module dftb_front #(
	parameter int MAX_DIM = dftb_pkg::MAX_DIM_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [dftb_pkg::START_W-1:0] fog_near,
	input  logic [dftb_pkg::START_W-1:0] fog_end,
	input  logic [dftb_pkg::DIM_W-1:0]   image_width,
	input  logic [dftb_pkg::DIM_W-1:0]   image_height,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [31:0]                  pixel_in,
	output logic                         push,
	output dftb_pkg::fe_t                push_data,
	input  logic                         full
);

	localparam int CNT_W = $clog2(MAX_DIM);
	localparam int EFF_W = $clog2(MAX_DIM + 1);
	localparam int NW    = (CNT_W + 10 > 19) ? CNT_W + 10 : 19;
	localparam int DW    = (EFF_W > dftb_pkg::START_W) ? EFF_W : dftb_pkg::START_W;
	localparam int FW    = dftb_pkg::FAC_W;
	localparam int SW    = dftb_pkg::START_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV1,
		S_FACT,
		S_DIV2,
		S_PUSH
	} state_t;

	function automatic logic [EFF_W-1:0] eff_dim(input logic [dftb_pkg::DIM_W-1:0] v);
		logic [EFF_W-1:0] r;
		if (v == '0) begin
			r = EFF_W'(1);
		end else if (32'(v) > 32'(MAX_DIM)) begin
			r = EFF_W'(MAX_DIM);
		end else begin
			r = EFF_W'(v);
		end
		return r;
	endfunction

	state_t           state_q;
	logic [CNT_W-1:0] col_q;
	logic [CNT_W-1:0] row_q;
	logic [FW-1:0]    fac_q;
	logic [9:0]       depth_q;
	logic [23:0]      px_q;

	logic [EFF_W-1:0] w_eff;
	logic [EFF_W-1:0] h_eff;
	logic             acc;
	logic             row_start;
	logic [CNT_W-1:0] row_base;
	logic [EFF_W-1:0] col_inc;
	logic [EFF_W-1:0] row_inc;

	logic [SW-1:0]    dep11;
	logic             empty_rng;
	logic [SW-1:0]    num_fog;
	logic [SW-1:0]    den_fog;
	logic             fact_div;
	logic [FW-1:0]    fact_val;

	logic             div_start;
	logic [NW-1:0]    div_num;
	logic [DW-1:0]    div_den;
	logic             div_done;
	logic [NW-1:0]    div_quo;

	always_comb begin
		w_eff     = eff_dim(image_width);
		h_eff     = eff_dim(image_height);
		in_ready  = (state_q == S_IDLE) && !full;
		acc       = in_valid && in_ready;
		row_start = col_q == '0;
		// height may have been lowered mid-frame
		if (row_start && (EFF_W'(row_q) >= h_eff)) begin
			row_base = '0;
		end else begin
			row_base = row_q;
		end
		col_inc = EFF_W'(col_q) + EFF_W'(1);
		row_inc = EFF_W'(row_base) + EFF_W'(1);

		dep11     = {1'b0, depth_q};
		empty_rng = fog_end <= fog_near;
		num_fog   = dep11 - fog_near;
		den_fog   = fog_end - fog_near;
		fact_div  = !empty_rng && (dep11 > fog_near) && (num_fog < den_fog);
		if (empty_rng) begin
			fact_val = (dep11 >= fog_near) ? dftb_pkg::FAC_ONE : '0;
		end else begin
			fact_val = (dep11 <= fog_near) ? '0 : dftb_pkg::FAC_ONE;
		end

		div_start = (acc && row_start) || ((state_q == S_FACT) && fact_div);
		if (state_q == S_FACT) begin
			div_num = NW'({num_fog, 8'b0});
			div_den = DW'(den_fog);
		end else begin
			// 768 * row
			div_num = NW'({row_base, 9'b0}) + NW'({row_base, 8'b0});
			div_den = DW'(h_eff);
		end

		push = (acc && !row_start) || ((state_q == S_PUSH) && !full);
		if (state_q == S_PUSH) begin
			push_data.rgb = px_q;
		end else begin
			push_data.rgb = pixel_in[23:0];
		end
		push_data.fac = fac_q;
	end

	dftb_div #(
		.NW(NW),
		.DW(DW)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (div_den),
		.done  (div_done),
		.quo   (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			col_q   <= '0;
			row_q   <= '0;
			fac_q   <= '0;
			depth_q <= '0;
			px_q    <= '0;
		end else begin
			if (acc) begin
				px_q <= pixel_in[23:0];
				if (col_inc >= w_eff) begin
					col_q <= '0;
					row_q <= (row_inc >= h_eff) ? '0 : CNT_W'(row_inc);
				end else begin
					col_q <= CNT_W'(col_inc);
					row_q <= row_base;
				end
			end
			case (state_q)
				S_IDLE: begin
					if (acc && row_start) begin
						state_q <= S_DIV1;
					end
				end
				S_DIV1: begin
					if (div_done) begin
						depth_q <= 10'd256 + div_quo[9:0];
						state_q <= S_FACT;
					end
				end
				S_FACT: begin
					if (fact_div) begin
						state_q <= S_DIV2;
					end else begin
						fac_q   <= fact_val;
						state_q <= S_PUSH;
					end
				end
				S_DIV2: begin
					if (div_done) begin
						fac_q   <= div_quo[FW-1:0];
						state_q <= S_PUSH;
					end
				end
				S_PUSH: begin
					if (!full) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`DFTB_ASSERT(a_fac_range, clk, arst_n, fac_q <= dftb_pkg::FAC_ONE)
	`DFTB_ASSERT_IMP(a_done_in_div, clk, arst_n, div_done, (state_q == S_DIV1) || (state_q == S_DIV2))
	`DFTB_ASSERT_NXT(a_row_start_div, clk, arst_n, acc && row_start, state_q == S_DIV1)

endmodule

[hdl/dftb_fifo.sv]
// Short queue between the front end and the blend pipeline.
// Uses dftb_pkg (entry type, depth) and the assertion macros header.
`include "depth_fog_tint_blend_top_macros.svh"

module dftb_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  dftb_pkg::fe_t wdata,
	input  logic          pop,
	output dftb_pkg::fe_t rdata,
	output logic          full,
	output logic          nonempty
);

	localparam int DEPTH = dftb_pkg::FIFO_DEPTH;
	localparam int PW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);

	dftb_pkg::fe_t mem [DEPTH];
	logic [PW-1:0] wp_q;
	logic [PW-1:0] rp_q;
	logic [CW-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + PW'(1);
			end
			if (pop) begin
				rp_q <= rp_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wp_q] <= wdata;
		end
	end

	assign rdata    = mem[rp_q];
	assign full     = cnt_q == CW'(DEPTH);
	assign nonempty = cnt_q != '0;

	`DFTB_ASSERT(a_cnt_range, clk, arst_n, cnt_q <= CW'(DEPTH))
	`DFTB_ASSERT_IMP(a_no_overflow, clk, arst_n, push, !full)
	`DFTB_ASSERT_IMP(a_no_underflow, clk, arst_n, pop, nonempty)

endmodule

[hdl/dftb_back.sv]
// Back end: three-stage tint and fog blend with saturation and output register.
// Uses dftb_pkg for widths, entry type and the alpha constant.
module dftb_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [dftb_pkg::COLOR_W-1:0] fog_color,
	input  logic [dftb_pkg::TINT_W-1:0]  tint_gains,
	input  logic                         q_valid,
	input  dftb_pkg::fe_t                q_data,
	output logic                         pop,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [31:0]                  pixel_out
);

	localparam int FW = dftb_pkg::FAC_W;

	logic          en;
	logic          v_s1;
	logic          v_s2;
	logic          v_s3;

	logic [16:0]   ct_s1 [3];
	logic [16:0]   gf_s1 [3];
	logic [FW-1:0] inv_s1;
	logic [26:0]   acc_s2 [3];
	logic [7:0]    ch_s3 [3];

	logic [7:0]    chan [3];
	logic [8:0]    tint [3];
	logic [7:0]    fogc [3];
	logic [10:0]   sat [3];

	// index 0 = blue, 1 = green, 2 = red
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			chan[i] = q_data.rgb[8*i +: 8];
			tint[i] = tint_gains[9*i +: 9];
			fogc[i] = fog_color[8*i +: 8];
			sat[i]  = acc_s2[i][26:16];
		end
	end

	// whole pipeline moves together; holds while the output is stalled
	assign en  = !v_s3 || out_ready;
	assign pop = q_valid && en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= q_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			inv_s1 <= dftb_pkg::FAC_ONE - q_data.fac;
			for (int i = 0; i < 3; i++) begin
				ct_s1[i]  <= 17'(chan[i]) * 17'(tint[i]);
				gf_s1[i]  <= 17'(fogc[i]) * 17'(q_data.fac);
				acc_s2[i] <= 27'(ct_s1[i]) * 27'(inv_s1) + 27'({gf_s1[i], 8'b0});
				ch_s3[i]  <= (sat[i] > 11'd255) ? 8'd255 : sat[i][7:0];
			end
		end
	end

	assign out_valid = v_s3;
	assign pixel_out = {dftb_pkg::ALPHA, ch_s3[2], ch_s3[1], ch_s3[0]};

endmodule

[hdl/depth_fog_tint_blend_top.sv]
// Depth fog / tint blend: top level with the configuration registers.
// Uses dftb_pkg, dftb_front, dftb_fifo and dftb_back.
//
// Usage: pixels enter on in_valid/in_ready/pixel_in in raster order, one
// transfer per pixel; each gives one pixel_out transfer on out_valid/out_ready,
// in order. Registers are written on cfg_valid/cfg_ready with cfg_index (0 fog
// start, 1 fog end, 2 fog color, 3 tint gains, 4 width, 5 height) and
// cfg_data; cfg_ready is always high, other indexes are dropped.
// Write registers only while no pixel is in flight.
// Throughput: one pixel per clock inside a row while the queue is not full.
// The first pixel of each row holds the input while the single serial
// divider computes the row depth and then, when the depth lies inside the
// fog range, the fog factor, one quotient bit per cycle. A mid-row pixel
// goes straight into the queue; a row-start pixel is pushed once the
// divider is done. Both then pass the blend pipeline to the output register.
// Reset clears the column and row counters and the row fog factor and loads
// the register defaults. A stalled receiver holds the output register; the
// blend pipeline and a four-entry queue then fill and in_ready drops.
module depth_fog_tint_blend_top #(
	parameter int MAX_DIM = dftb_pkg::MAX_DIM_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [31:0]                 pixel_in,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [31:0]                 pixel_out,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [dftb_pkg::IDX_W-1:0]  cfg_index,
	input  logic [dftb_pkg::DATA_W-1:0] cfg_data
);

	logic [dftb_pkg::START_W-1:0] fog_near_q;
	logic [dftb_pkg::START_W-1:0] fog_end_q;
	logic [dftb_pkg::COLOR_W-1:0] fog_color_q;
	logic [dftb_pkg::TINT_W-1:0]  tint_q;
	logic [dftb_pkg::DIM_W-1:0]   width_q;
	logic [dftb_pkg::DIM_W-1:0]   height_q;

	logic          push;
	dftb_pkg::fe_t push_data;
	logic          full;
	logic          pop;
	dftb_pkg::fe_t q_data;
	logic          q_valid;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fog_near_q  <= dftb_pkg::FOG_NEAR_RST;
			fog_end_q   <= dftb_pkg::FOG_END_RST;
			fog_color_q <= dftb_pkg::FOG_COLOR_RST;
			tint_q      <= dftb_pkg::TINT_RST;
			width_q     <= dftb_pkg::WIDTH_RST;
			height_q    <= dftb_pkg::HEIGHT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				dftb_pkg::REG_FOG_NEAR:  fog_near_q  <= cfg_data[dftb_pkg::START_W-1:0];
				dftb_pkg::REG_FOG_END:   fog_end_q   <= cfg_data[dftb_pkg::START_W-1:0];
				dftb_pkg::REG_FOG_COLOR: fog_color_q <= cfg_data[dftb_pkg::COLOR_W-1:0];
				dftb_pkg::REG_TINT:      tint_q      <= cfg_data[dftb_pkg::TINT_W-1:0];
				dftb_pkg::REG_WIDTH:     width_q     <= cfg_data[dftb_pkg::DIM_W-1:0];
				dftb_pkg::REG_HEIGHT:    height_q    <= cfg_data[dftb_pkg::DIM_W-1:0];
				default: begin
				end
			endcase
		end
	end

	dftb_front #(
		.MAX_DIM(MAX_DIM)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.fog_near    (fog_near_q),
		.fog_end     (fog_end_q),
		.image_width (width_q),
		.image_height(height_q),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.pixel_in    (pixel_in),
		.push        (push),
		.push_data   (push_data),
		.full        (full)
	);

	dftb_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wdata   (push_data),
		.pop     (pop),
		.rdata   (q_data),
		.full    (full),
		.nonempty(q_valid)
	);

	dftb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.fog_color (fog_color_q),
		.tint_gains(tint_q),
		.q_valid   (q_valid),
		.q_data    (q_data),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.pixel_out (pixel_out)
	);

endmodule

[sim/tb.sv]
// Self-checking testbench for depth_fog_tint_blend_top: a directed table followed by random
// frames with random register settings, checked against a local fog/tint predictor.
// Depends on hdl/dftb_pkg.sv and the RTL under hdl.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned RAND_ITEMS   = 1900;
	localparam int unsigned LIMIT_CYCLES = 1_000_000;
	localparam int unsigned HOLD_CYCLES  = 300;
	localparam int unsigned IDLE_PAD     = 4;
	localparam int unsigned TAIL_CYCLES  = 60;
	localparam int unsigned MAX_REPORTS  = 10;

	localparam int IDX_W  = dftb_pkg::IDX_W;
	localparam int DATA_W = dftb_pkg::DATA_W;
	localparam int FAC_W  = dftb_pkg::FAC_W;
	localparam int DIM_W  = dftb_pkg::DIM_W;

	localparam logic [DATA_W-1:0] TINT_UNITY = {9'd256, 9'd256, 9'd256};
	localparam logic [DATA_W-1:0] ALL_ONES   = {DATA_W{1'b1}};

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [31:0]        pixel_in = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [31:0]        pixel_out;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [IDX_W-1:0]   cfg_index = '0;
	logic [DATA_W-1:0]  cfg_data = '0;

	always #10 clk = ~clk;

	depth_fog_tint_blend_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.pixel_in  (pixel_in),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.pixel_out (pixel_out),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// predictor copy of the registers and the raster state
	logic [dftb_pkg::START_W-1:0] cfg_near   = dftb_pkg::FOG_NEAR_RST;
	logic [dftb_pkg::START_W-1:0] cfg_end    = dftb_pkg::FOG_END_RST;
	logic [dftb_pkg::COLOR_W-1:0] cfg_color  = dftb_pkg::FOG_COLOR_RST;
	logic [dftb_pkg::TINT_W-1:0]  cfg_tint   = dftb_pkg::TINT_RST;
	logic [DIM_W-1:0]             cfg_width  = dftb_pkg::WIDTH_RST;
	logic [DIM_W-1:0]             cfg_height = dftb_pkg::HEIGHT_RST;
	int unsigned        col_pos = 0;
	int unsigned        row_pos = 0;
	logic [FAC_W-1:0]   row_fac = '0;

	logic [31:0] fogged_q[$];
	int unsigned errors = 0;
	int unsigned cycles = 0;
	int unsigned burst_left = 0;
	int unsigned hold_asks = 0;

	function automatic int unsigned dim_eff(input logic [DIM_W-1:0] v);
		if (v == 0)
			return 1;
		if (32'(v) > dftb_pkg::MAX_DIM_DEF)
			return dftb_pkg::MAX_DIM_DEF;
		return 32'(v);
	endfunction

	function automatic logic [FAC_W-1:0] row_factor(input int unsigned row, input int unsigned h);
		longint depth, st, en, num, den;
		depth = 256 + (768 * longint'(row)) / longint'(h);
		st = longint'(cfg_near);
		en = longint'(cfg_end);
		if (en <= st)
			return (depth >= st) ? dftb_pkg::FAC_ONE : '0;
		num = depth - st;
		den = en - st;
		if (num <= 0)
			return '0;
		if (num >= den)
			return dftb_pkg::FAC_ONE;
		return FAC_W'((num * 256) / den);
	endfunction

	function automatic logic [7:0] blend_ch(input logic [7:0] c, input logic [8:0] t,
			input logic [7:0] g, input logic [FAC_W-1:0] f);
		logic [63:0] acc;
		acc = (64'(c) * 64'(t) * (64'(256) - 64'(f)) + 64'(g) * 64'(f) * 64'(256)) >> 16;
		return (acc > 255) ? 8'hFF : acc[7:0];
	endfunction

	// advances the raster state by one pixel and returns the fogged pixel
	function automatic logic [31:0] fog_predict(input logic [31:0] px);
		int unsigned w, h;
		logic [7:0] r, g, b;
		w = dim_eff(cfg_width);
		h = dim_eff(cfg_height);
		if (col_pos == 0) begin
			if (row_pos >= h)
				row_pos = 0;
			row_fac = row_factor(row_pos, h);
		end
		r = blend_ch(px[23:16], cfg_tint[26:18], cfg_color[23:16], row_fac);
		g = blend_ch(px[15:8], cfg_tint[17:9], cfg_color[15:8], row_fac);
		b = blend_ch(px[7:0], cfg_tint[8:0], cfg_color[7:0], row_fac);
		col_pos++;
		if (col_pos >= w) begin
			col_pos = 0;
			row_pos++;
			if (row_pos >= h)
				row_pos = 0;
		end
		return {dftb_pkg::ALPHA, r, g, b};
	endfunction

	function automatic void fog_cfg_apply(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] d);
		case (idx)
		dftb_pkg::REG_FOG_NEAR:  cfg_near = d[dftb_pkg::START_W-1:0];
		dftb_pkg::REG_FOG_END:   cfg_end = d[dftb_pkg::START_W-1:0];
		dftb_pkg::REG_FOG_COLOR: cfg_color = d[dftb_pkg::COLOR_W-1:0];
		dftb_pkg::REG_TINT:      cfg_tint = d[dftb_pkg::TINT_W-1:0];
		dftb_pkg::REG_WIDTH:     cfg_width = d[DIM_W-1:0];
		dftb_pkg::REG_HEIGHT:    cfg_height = d[DIM_W-1:0];
		default: ;
		endcase
	endfunction

	// sender: bursts of random length with random gaps in between
	task automatic push_pixel(input logic [31:0] px, input logic typed, input logic [31:0] want);
		int unsigned gap;
		logic [31:0] fp;
		@(negedge clk);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		pixel_in <= px;
		do @(posedge clk); while (!in_ready);
		fp = fog_predict(px);
		fogged_q.push_back(typed ? want : fp);
	endtask

	// drop valid and wait for every outstanding pixel
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (fogged_q.size() != 0)
			@(posedge clk);
		repeat (IDLE_PAD) @(posedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] d);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		fog_cfg_apply(idx, d);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// receiver: random stall pattern, plus long hold-offs on request
	int unsigned hold_done = 0;
	int unsigned hold_left = 0;
	int unsigned rx_left = 0;
	int unsigned rx_mode = 0;
	always @(negedge clk) begin
		if (hold_left != 0) begin
			hold_left = hold_left - 1;
			out_ready <= 1'b0;
		end else if (hold_done != hold_asks) begin
			hold_done = hold_asks;
			hold_left = HOLD_CYCLES;
			out_ready <= 1'b0;
		end else begin
			if (rx_left == 0) begin
				rx_left = $urandom_range(1, 20);
				rx_mode = $urandom_range(0, 5);
			end
			rx_left--;
			// mode 0 never stalls; higher modes stall less often
			out_ready <= (rx_mode == 0) ? 1'b1 : ($urandom_range(0, rx_mode) != 0);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (fogged_q.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("unexpected pixel transfer: got %h", pixel_out);
			end else begin
				if (pixel_out !== fogged_q[0]) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("pixel_out mismatch: expected %h, got %h", fogged_q[0], pixel_out);
				end
				void'(fogged_q.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("timeout after %0d cycles", cycles);
			$display("*** FAILED ***");
			$finish;
		end
	end

	typedef struct packed {
		logic              wr;
		logic [IDX_W-1:0]  idx;
		logic [DATA_W-1:0] data;
		logic [31:0]       px;
		logic              typed;
		logic [31:0]       want;
	} dir_row_t;

	dir_row_t dir_tab[$];

	function automatic void tab_wr(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] d);
		dir_tab.push_back({1'b1, idx, d, 32'h0, 1'b0, 32'h0});
	endfunction

	function automatic void tab_px(input logic [31:0] px);
		dir_tab.push_back({1'b0, {IDX_W{1'b0}}, {DATA_W{1'b0}}, px, 1'b0, 32'h0});
	endfunction

	function automatic void tab_chk(input logic [31:0] px, input logic [31:0] want);
		dir_tab.push_back({1'b0, {IDX_W{1'b0}}, {DATA_W{1'b0}}, px, 1'b1, want});
	endfunction

	initial begin
		int unsigned sent, n_items, n_wr, sel, phase;
		logic [IDX_W-1:0] widx;
		logic [DATA_W-1:0] wdat;

		// defaults after reset: row 0 sits before the fog start
		tab_chk(32'h0000_0000, 32'hFF00_0000);
		tab_px(32'hFFFF_FFFF);
		tab_px(32'h0080_A5C3);
		// unity gains, fog never reached, zero frame size acting as 1x1
		tab_wr(dftb_pkg::REG_TINT, TINT_UNITY);
		tab_wr(dftb_pkg::REG_FOG_NEAR, 27'd2047);
		tab_wr(dftb_pkg::REG_FOG_END, '0);
		tab_wr(dftb_pkg::REG_WIDTH, '0);
		tab_wr(dftb_pkg::REG_HEIGHT, '0);
		tab_chk(32'hFF12_3456, 32'hFF12_3456);
		tab_chk(32'h00FF_FFFF, 32'hFFFF_FFFF);
		tab_chk(32'h0000_0000, 32'hFF00_0000);
		// empty fog range with depth past start: full fog color
		tab_wr(dftb_pkg::REG_FOG_NEAR, '0);
		tab_wr(dftb_pkg::REG_FOG_COLOR, 27'hABCDEF);
		tab_chk(32'h00FF_FFFF, 32'hFFAB_CDEF);
		tab_chk(32'h5A00_0000, 32'hFFAB_CDEF);
		// max gains saturate; oversized frame; upper data bits ignored
		tab_wr(dftb_pkg::REG_TINT, ALL_ONES);
		tab_wr(dftb_pkg::REG_FOG_END, ALL_ONES);
		tab_wr(dftb_pkg::REG_FOG_COLOR, '0);
		tab_wr(dftb_pkg::REG_WIDTH, ALL_ONES);
		tab_wr(dftb_pkg::REG_HEIGHT, ALL_ONES);
		tab_px(32'h00FF_FFFF);
		tab_px(32'h0001_0203);
		tab_px(32'hC3F0_0FFF);
		// narrow rows crossing row boundaries, zero gains, white fog
		tab_wr(dftb_pkg::REG_WIDTH, 27'd3);
		tab_wr(dftb_pkg::REG_HEIGHT, 27'd5000);
		tab_wr(dftb_pkg::REG_FOG_NEAR, 27'd256);
		tab_wr(dftb_pkg::REG_FOG_END, 27'd1024);
		tab_wr(dftb_pkg::REG_TINT, '0);
		tab_wr(dftb_pkg::REG_FOG_COLOR, 27'hFFFFFF);
		tab_px(32'h0011_2233);
		tab_px(32'h8044_5566);
		tab_px(32'h0077_8899);
		tab_px(32'h00AA_BBCC);
		tab_px(32'h00CC_DDEE);
		tab_px(32'h0001_0101);
		// height lowered below the current row at a row start
		tab_wr(dftb_pkg::REG_WIDTH, 27'd2);
		tab_wr(dftb_pkg::REG_HEIGHT, 27'd1);
		tab_wr(dftb_pkg::REG_TINT, TINT_UNITY);
		tab_px(32'h00DD_EEFF);
		tab_px(32'h0010_2030);
		tab_px(32'hFF40_5060);

		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (dir_tab[i]) begin
			if (dir_tab[i].wr) begin
				if (i == 0 || !dir_tab[i-1].wr)
					settle();
				write_reg(dir_tab[i].idx, dir_tab[i].data);
			end else
				push_pixel(dir_tab[i].px, dir_tab[i].typed, dir_tab[i].want);
		end

		sent = 0;
		phase = 0;
		while (sent < RAND_ITEMS) begin
			settle();
			n_wr = $urandom_range(1, 8);
			for (int k = 0; k < n_wr; k++) begin
				widx = IDX_W'($urandom_range(0, 7));
				sel = $urandom_range(0, 7);
				wdat = DATA_W'($urandom);
				case (widx)
				dftb_pkg::REG_FOG_NEAR, dftb_pkg::REG_FOG_END: begin
					if (sel >= 3)
						wdat = DATA_W'($urandom_range(200, 1100));
					else if (sel == 2)
						wdat = DATA_W'($urandom_range(0, 2047));
				end
				dftb_pkg::REG_WIDTH, dftb_pkg::REG_HEIGHT: begin
					if (sel == 1)
						wdat = '0;
					else if (sel == 2)
						wdat = DATA_W'(dftb_pkg::MAX_DIM_DEF);
					else if (sel >= 3)
						wdat = DATA_W'($urandom_range(1, 12));
				end
				default: ;
				endcase
				write_reg(widx, wdat);
			end
			// long receiver hold-off while the sender keeps offering pixels
			if (phase == 1 || phase % 9 == 5)
				hold_asks++;
			n_items = $urandom_range(20, 120);
			for (int k = 0; k < n_items; k++) begin
				push_pixel($urandom, 1'b0, 32'h0);
				if (phase == 2 && k == n_items / 2)
					settle();
			end
			sent += n_items;
			phase++;
		end

		settle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0 && fogged_q.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule
